>>> src/rbd_pkg.sv
package rbd_pkg;

   localparam int PIX_W      = 8;
   localparam int RUN_W      = 10;
   localparam int ROW_W      = 11;
   localparam int COL_W      = 12;
   localparam int NUM_CH     = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam int SRC_CNT_W  = 12;
   localparam int SRC_CFG_W  = 13;
   localparam int OW_CFG_W   = 11;
   localparam int OH_CFG_W   = 13;
   localparam int OLINE_W    = 13;

   localparam logic [SRC_CFG_W-1:0] SRC_DIM_MAX = 13'd4096;
   localparam logic [OH_CFG_W-1:0]  OUT_H_MAX   = 13'd4096;

   localparam logic [SRC_CFG_W-1:0] SRC_W_RST = 13'd1920;
   localparam logic [SRC_CFG_W-1:0] SRC_H_RST = 13'd1080;
   localparam logic [OW_CFG_W-1:0]  OUT_W_RST = 11'd640;
   localparam logic [OH_CFG_W-1:0]  OUT_H_RST = 13'd360;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SOURCE_WIDTH,
      CSR_SOURCE_HEIGHT,
      CSR_OUTPUT_WIDTH,
      CSR_OUTPUT_HEIGHT
   } csr_index_type;

   // channel 0 blue, 1 green, 2 red
   typedef logic [NUM_CH-1:0][PIX_W-1:0] pix_vec_type;
   typedef logic [NUM_CH-1:0][RUN_W-1:0] run_vec_type;
   typedef logic [NUM_CH-1:0][ROW_W-1:0] row_vec_type;
   typedef logic [NUM_CH-1:0][COL_W-1:0] col_vec_type;

   typedef struct packed {
      logic close;
      logic first;
      logic emit;
      logic line_end;
      logic frame_end;
   } op_type;

   typedef struct packed {
      col_vec_type total;
      logic        line_end;
      logic        frame_end;
   } blk_type;

endpackage

>>> src/rbd_if.sv
interface rbd_req_if;
   logic                      valid;
   logic                      ready;
   logic [rbd_pkg::PIX_W-1:0] blue_in;
   logic [rbd_pkg::PIX_W-1:0] green_in;
   logic [rbd_pkg::PIX_W-1:0] red_in;
   logic                      frame_start;

   modport source (output valid, blue_in, green_in, red_in, frame_start, input ready);
   modport sink (input valid, blue_in, green_in, red_in, frame_start, output ready);
endinterface

interface rbd_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [rbd_pkg::PIX_W-1:0] blue_avg;
   logic [rbd_pkg::PIX_W-1:0] green_avg;
   logic [rbd_pkg::PIX_W-1:0] red_avg;
   logic                      line_end;
   logic                      frame_end;

   modport source (output valid, blue_avg, green_avg, red_avg, line_end, frame_end,
                   input ready);
   modport sink (input valid, blue_avg, green_avg, red_avg, line_end, frame_end,
                 output ready);
endinterface

>>> src/rbd_pos.sv
module rbd_pos #(
   parameter int FACTOR        = 3,
   parameter int MAX_OUT_WIDTH = 1024,
   parameter int ADDR_W        = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  rbd_pkg::csr_index_type         csr_index,
   input  logic [rbd_pkg::CSR_DATA_W-1:0] csr_wr_data,
   input  logic                           accept,
   input  rbd_pkg::pix_vec_type           pix,
   input  logic                           frame_start,
   output rbd_pkg::op_type                op,
   output logic [ADDR_W-1:0]              addr,
   output rbd_pkg::row_vec_type           row
);
   import rbd_pkg::*;

   localparam int OCOL_W = $clog2(MAX_OUT_WIDTH + 1);
   localparam int SUB_W  = $clog2(FACTOR);
   localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(FACTOR - 1);

   logic [SRC_CFG_W-1:0] src_w_cfg_ff;
   logic [SRC_CFG_W-1:0] src_h_cfg_ff;
   logic [OW_CFG_W-1:0]  out_w_cfg_ff;
   logic [OH_CFG_W-1:0]  out_h_cfg_ff;

   logic [SRC_CFG_W-1:0] src_w;
   logic [SRC_CFG_W-1:0] src_h;
   logic [OCOL_W-1:0]    out_w;
   logic [OH_CFG_W-1:0]  out_h;

   logic [SRC_CNT_W-1:0] scol_ff, scol_in, cur_scol;
   logic [SRC_CNT_W-1:0] sline_ff, sline_in, cur_sline;
   logic [SUB_W-1:0]     subc_ff, subc_in, cur_subc;
   logic [SUB_W-1:0]     subl_ff, subl_in, cur_subl;
   logic [OCOL_W-1:0]    ocol_ff, ocol_in, cur_ocol;
   logic [OLINE_W-1:0]   oline_ff, oline_in, cur_oline;
   run_vec_type          run_ff, run_in, cur_run;

   logic [SRC_CFG_W-1:0] scol_next;
   logic [SRC_CFG_W-1:0] sline_next;
   logic                 in_region;
   logic                 close;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_cfg_ff <= SRC_W_RST;
         src_h_cfg_ff <= SRC_H_RST;
         out_w_cfg_ff <= OUT_W_RST;
         out_h_cfg_ff <= OUT_H_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SOURCE_WIDTH:  src_w_cfg_ff <= csr_wr_data[SRC_CFG_W-1:0];
            CSR_SOURCE_HEIGHT: src_h_cfg_ff <= csr_wr_data[SRC_CFG_W-1:0];
            CSR_OUTPUT_WIDTH:  out_w_cfg_ff <= csr_wr_data[OW_CFG_W-1:0];
            CSR_OUTPUT_HEIGHT: out_h_cfg_ff <= csr_wr_data[OH_CFG_W-1:0];
         endcase
      end
   end

   // registers saturate to the supported frame sizes, and zero source sizes read as one
   always_comb begin
      if (src_w_cfg_ff == '0) begin
         src_w = SRC_CFG_W'(1);
      end else if (src_w_cfg_ff > SRC_DIM_MAX) begin
         src_w = SRC_DIM_MAX;
      end else begin
         src_w = src_w_cfg_ff;
      end
      if (src_h_cfg_ff == '0) begin
         src_h = SRC_CFG_W'(1);
      end else if (src_h_cfg_ff > SRC_DIM_MAX) begin
         src_h = SRC_DIM_MAX;
      end else begin
         src_h = src_h_cfg_ff;
      end
      if (32'(out_w_cfg_ff) > 32'(MAX_OUT_WIDTH)) begin
         out_w = OCOL_W'(MAX_OUT_WIDTH);
      end else begin
         out_w = OCOL_W'(out_w_cfg_ff);
      end
      out_h = (out_h_cfg_ff > OUT_H_MAX) ? OUT_H_MAX : out_h_cfg_ff;
   end

   // a frame start mark clears the position before the pixel is used
   always_comb begin
      cur_scol  = frame_start ? '0 : scol_ff;
      cur_sline = frame_start ? '0 : sline_ff;
      cur_subc  = frame_start ? '0 : subc_ff;
      cur_subl  = frame_start ? '0 : subl_ff;
      cur_ocol  = frame_start ? '0 : ocol_ff;
      cur_oline = frame_start ? '0 : oline_ff;
      cur_run   = frame_start ? '0 : run_ff;
   end

   always_comb begin
      in_region  = (cur_oline < out_h) && (cur_ocol < out_w);
      close      = in_region && (cur_subc == SUB_LAST);
      scol_next  = {1'b0, cur_scol} + SRC_CFG_W'(1);
      sline_next = {1'b0, cur_sline} + SRC_CFG_W'(1);
      for (int c = 0; c < NUM_CH; c++) begin
         row[c] = ROW_W'(cur_run[c]) + ROW_W'(pix[c]);
      end
   end

   always_comb begin
      scol_in  = scol_ff;
      sline_in = sline_ff;
      subc_in  = subc_ff;
      subl_in  = subl_ff;
      ocol_in  = ocol_ff;
      oline_in = oline_ff;
      run_in   = run_ff;
      if (accept) begin
         scol_in  = scol_next[SRC_CNT_W-1:0];
         sline_in = cur_sline;
         subc_in  = cur_subc;
         subl_in  = cur_subl;
         ocol_in  = cur_ocol;
         oline_in = cur_oline;
         run_in   = cur_run;
         if (close) begin
            run_in  = '0;
            subc_in = '0;
            ocol_in = cur_ocol + 1'b1;
         end else if (in_region) begin
            for (int c = 0; c < NUM_CH; c++) begin
               run_in[c] = row[c][RUN_W-1:0];
            end
            subc_in = cur_subc + 1'b1;
         end
         if (scol_next >= src_w) begin
            scol_in = '0;
            subc_in = '0;
            ocol_in = '0;
            run_in  = '0;
            if (cur_oline < out_h) begin
               if (cur_subl == SUB_LAST) begin
                  subl_in  = '0;
                  oline_in = cur_oline + 1'b1;
               end else begin
                  subl_in = cur_subl + 1'b1;
               end
            end
            // wrap at the frame end as if a mark had come
            if (sline_next >= src_h) begin
               sline_in = '0;
               subl_in  = '0;
               oline_in = '0;
            end else begin
               sline_in = sline_next[SRC_CNT_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scol_ff  <= '0;
         sline_ff <= '0;
         subc_ff  <= '0;
         subl_ff  <= '0;
         ocol_ff  <= '0;
         oline_ff <= '0;
         run_ff   <= '0;
      end else begin
         scol_ff  <= scol_in;
         sline_ff <= sline_in;
         subc_ff  <= subc_in;
         subl_ff  <= subl_in;
         ocol_ff  <= ocol_in;
         oline_ff <= oline_in;
         run_ff   <= run_in;
      end
   end

   always_comb begin
      op.close     = close;
      op.first     = (cur_subl == '0);
      op.emit      = (cur_subl == SUB_LAST);
      op.line_end  = (({1'b0, cur_ocol} + 1'b1) == {1'b0, out_w});
      op.frame_end = op.line_end && ((cur_oline + 1'b1) == out_h);
      addr         = cur_ocol[ADDR_W-1:0];
   end

endmodule

>>> src/rbd_store.sv
module rbd_store #(
   parameter int MAX_OUT_WIDTH = 1024,
   parameter int ADDR_W        = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  rbd_pkg::op_type      op,
   input  logic [ADDR_W-1:0]    addr,
   input  rbd_pkg::row_vec_type row,
   output logic                 ready,
   output logic                 blk_valid,
   output rbd_pkg::blk_type     blk,
   input  logic                 blk_ready
);
   import rbd_pkg::*;

   col_vec_type line_mem [MAX_OUT_WIDTH];

   logic              s1_valid_ff, s1_valid_in;
   op_type            s1_op_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   row_vec_type       s1_row_ff;
   col_vec_type       rd_data_ff;

   logic        s1_adv;
   logic        rd_en;
   col_vec_type total;

   // the slot frees when its transaction needs no result or the result stage takes it
   assign s1_adv = !s1_valid_ff || !s1_op_ff.emit || blk_ready;
   assign ready  = s1_adv;

   // first sub-row overwrites, so only later sub-rows read back
   assign rd_en = accept && op.close && !op.first;

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         total[c] = s1_op_ff.first ? COL_W'(s1_row_ff[c])
                                   : rd_data_ff[c] + COL_W'(s1_row_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_adv) begin
         line_mem[s1_addr_ff] <= total;
      end
      if (rd_en) begin
         rd_data_ff <= line_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_op_ff   <= op;
         s1_addr_ff <= addr;
         s1_row_ff  <= row;
      end
   end

   assign s1_valid_in = s1_adv ? (accept && op.close) : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   assign blk_valid     = s1_valid_ff && s1_op_ff.emit;
   assign blk.total     = total;
   assign blk.line_end  = s1_op_ff.line_end;
   assign blk.frame_end = s1_op_ff.frame_end;

`ifndef SYNTHESIS
   a_no_rmw_overlap: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rd_en) |-> (addr != s1_addr_ff))
      else $error("line store read hits the column still being written");
   a_first_not_last: assert property (@(posedge clock) disable iff (reset)
      (accept && op.close) |-> !(op.first && op.emit))
      else $error("block closes on its first and last sub-row at once");
   a_room_for_result: assert property (@(posedge clock) disable iff (reset)
      (accept && s1_valid_ff && s1_op_ff.emit) |-> blk_ready)
      else $error("transaction taken while a block result has nowhere to go");
`endif

endmodule

>>> src/rbd_avg.sv
module rbd_avg #(
   parameter int FACTOR = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             blk_valid,
   input  rbd_pkg::blk_type blk,
   output logic             blk_ready,
   rbd_rsp_if.source        rsp
);
   import rbd_pkg::*;

   localparam int DIV     = FACTOR * FACTOR;
   localparam int SHIFT   = COL_W + $clog2(DIV);
   localparam int MULT_W  = COL_W + 1;
   localparam int PROD_W  = COL_W + MULT_W;
   // rounded-up reciprocal, exact for every sum below 2**COL_W
   localparam logic [MULT_W-1:0] MULT = MULT_W'(((1 << SHIFT) + DIV - 1) / DIV);

   logic        s2_valid_ff, s2_valid_in;
   blk_type     s2_blk_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   pix_vec_type quot_ff;
   logic        line_end_ff;
   logic        frame_end_ff;

   logic                           rsp_free;
   logic [NUM_CH-1:0][PROD_W-1:0] prod;
   pix_vec_type                    quot;

   assign rsp_free  = !rsp_valid_ff || rsp.ready;
   assign blk_ready = !s2_valid_ff || rsp_free;

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         prod[c] = PROD_W'(s2_blk_ff.total[c]) * PROD_W'(MULT);
         quot[c] = prod[c][SHIFT +: PIX_W];
      end
   end

   assign s2_valid_in  = blk_ready ? blk_valid : s2_valid_ff;
   assign rsp_valid_in = rsp_free ? s2_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (blk_ready) begin
         s2_blk_ff <= blk;
      end
      if (rsp_free) begin
         quot_ff      <= quot;
         line_end_ff  <= s2_blk_ff.line_end;
         frame_end_ff <= s2_blk_ff.frame_end;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.blue_avg  = quot_ff[0];
   assign rsp.green_avg = quot_ff[1];
   assign rsp.red_avg   = quot_ff[2];
   assign rsp.line_end  = line_end_ff;
   assign rsp.frame_end = frame_end_ff;

endmodule

>>> src/rgb_box_downscale_top.sv
// path: after the edge that accepts a block's last pixel, the result goes through the line
// store read, the column sum add and write back, and the reciprocal multiply into the output
// register before rsp valid rises
// throughput: one source pixel per cycle, unless a finished block waits for the result side
// reset: synchronous; counters, run sums, settings and valid flags go to defaults at once,
// the line store is not cleared since each block's first sub-row overwrites its column sums
module rgb_box_downscale_top #(
   parameter int FACTOR        = 3,
   parameter int MAX_OUT_WIDTH = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   rbd_req_if.sink                        req_port,
   rbd_rsp_if.source                      rsp_port,
   input  logic                           csr_wr_en,
   input  rbd_pkg::csr_index_type         csr_index,
   input  logic [rbd_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import rbd_pkg::*;

   localparam int ADDR_W = $clog2(MAX_OUT_WIDTH);

   logic              accept;
   logic              store_ready;
   pix_vec_type       pix;
   op_type            op;
   logic [ADDR_W-1:0] addr;
   row_vec_type       row;
   logic              blk_valid;
   blk_type           blk;
   logic              blk_ready;

   assign req_port.ready = store_ready;
   assign accept         = req_port.valid && store_ready;
   assign pix            = {req_port.red_in, req_port.green_in, req_port.blue_in};

   rbd_pos #(
      .FACTOR        (FACTOR),
      .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
      .ADDR_W        (ADDR_W)
   ) u_pos (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .pix         (pix),
      .frame_start (req_port.frame_start),
      .op          (op),
      .addr        (addr),
      .row         (row)
   );

   rbd_store #(
      .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
      .ADDR_W        (ADDR_W)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .op        (op),
      .addr      (addr),
      .row       (row),
      .ready     (store_ready),
      .blk_valid (blk_valid),
      .blk       (blk),
      .blk_ready (blk_ready)
   );

   rbd_avg #(
      .FACTOR (FACTOR)
   ) u_avg (
      .clock     (clock),
      .reset     (reset),
      .blk_valid (blk_valid),
      .blk       (blk),
      .blk_ready (blk_ready),
      .rsp       (rsp_port)
   );

endmodule

>>> verif/tb.sv
module tb;
   import rbd_pkg::*;

   localparam int FACTOR      = 3;
   localparam int MAX_OUT_W   = 1024;
   localparam int DIM_MAX     = 4096;
   localparam int SETTLE      = 8;        // a little beyond the three-stage pipeline
   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 4_000_000;

   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
      logic             line_end;
      logic             frame_end;
   } avg_pixel_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   rbd_req_if req_bus ();
   rbd_rsp_if rsp_bus ();

   rgb_box_downscale_top #(
      .FACTOR        (FACTOR),
      .MAX_OUT_WIDTH (MAX_OUT_W)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_bus),
      .rsp_port    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // register copies as written
   logic [SRC_CFG_W-1:0] set_src_w;
   logic [SRC_CFG_W-1:0] set_src_h;
   logic [OW_CFG_W-1:0]  set_out_w;
   logic [OH_CFG_W-1:0]  set_out_h;

   // scaler position and sums
   col_vec_type col_store [MAX_OUT_W];
   run_vec_type run_acc;
   int unsigned src_col, src_row;
   int unsigned blk_sub_col, blk_sub_row;
   int unsigned blk_col, blk_row;

   avg_pixel_type pending_averages [$];

   int unsigned pixels_sent;
   int unsigned pixels_used;
   int unsigned results_due;
   int unsigned results_seen;
   int unsigned settings_applied;
   int unsigned mismatches;
   int unsigned cycle_count;

   int  req_calm;
   bit  no_req_gaps;
   int  rsp_stall;
   int  rsp_calm;
   int  hold_left;
   int  hold_requests;
   int  hold_taken;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: run stopped after %0d cycles with %0d averaged pixels outstanding",
               $time, cycle_count, pending_averages.size());
      $display("FAIL");
      $finish;
   end

   function automatic int unsigned effective_dim(input logic [SRC_CFG_W-1:0] v);
      if (v == 0)
         return 1;
      if (v > DIM_MAX)
         return DIM_MAX;
      return 32'(v);
   endfunction

   function automatic void restart_frame();
      src_col     = 0;
      src_row     = 0;
      blk_sub_col = 0;
      blk_sub_row = 0;
      blk_col     = 0;
      blk_row     = 0;
      run_acc     = '0;
   endfunction

   // one source pixel through the box filter, queueing the block average when it completes
   function automatic void accumulate_pixel(input pix_vec_type pix, input logic fs);
      int unsigned   sw, sh, ow, oh;
      int unsigned   col, row;
      int            ch;
      col_vec_type   total;
      avg_pixel_type avg;

      sw = effective_dim(set_src_w);
      sh = effective_dim(set_src_h);
      ow = (set_out_w > MAX_OUT_W) ? MAX_OUT_W : set_out_w;
      oh = (set_out_h > DIM_MAX) ? DIM_MAX : set_out_h;
      if (fs)
         restart_frame();

      if (blk_row < oh && blk_col < ow) begin
         pixels_used++;
         if (blk_sub_col == FACTOR - 1) begin
            col = blk_col % MAX_OUT_W;
            for (ch = 0; ch < NUM_CH; ch++) begin
               row = run_acc[ch] + pix[ch];
               if (blk_sub_row == 0)
                  total[ch] = COL_W'(row);
               else
                  total[ch] = COL_W'(col_store[col][ch] + row);
               col_store[col][ch] = total[ch];
               run_acc[ch] = '0;
            end
            if (blk_sub_row == FACTOR - 1) begin
               avg.blue      = PIX_W'(total[0] / (FACTOR * FACTOR));
               avg.green     = PIX_W'(total[1] / (FACTOR * FACTOR));
               avg.red       = PIX_W'(total[2] / (FACTOR * FACTOR));
               avg.line_end  = (blk_col + 1 == ow);
               avg.frame_end = avg.line_end && (blk_row + 1 == oh);
               pending_averages.push_back(avg);
               results_due++;
            end
            blk_sub_col = 0;
            blk_col++;
         end else begin
            for (ch = 0; ch < NUM_CH; ch++)
               run_acc[ch] = run_acc[ch] + pix[ch];
            blk_sub_col++;
         end
      end

      src_col++;
      if (src_col >= sw) begin
         src_col     = 0;
         blk_sub_col = 0;
         blk_col     = 0;
         run_acc     = '0;
         if (blk_row < oh) begin
            blk_sub_row++;
            if (blk_sub_row >= FACTOR) begin
               blk_sub_row = 0;
               blk_row++;
            end
         end
         src_row++;
         if (src_row >= sh)
            restart_frame();
      end
   endfunction

   function automatic void check_field(input string name, input logic [PIX_W-1:0] want,
                                       input logic [PIX_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      avg_pixel_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (pending_averages.size() == 0) begin
            $display("%0t: averaged pixel with none due, got blue %0d green %0d red %0d",
                     $time, rsp_bus.blue_avg, rsp_bus.green_avg, rsp_bus.red_avg);
            mismatches++;
         end else begin
            want = pending_averages.pop_front();
            check_field("blue_avg", want.blue, rsp_bus.blue_avg);
            check_field("green_avg", want.green, rsp_bus.green_avg);
            check_field("red_avg", want.red, rsp_bus.red_avg);
            check_field("line_end", PIX_W'(want.line_end), PIX_W'(rsp_bus.line_end));
            check_field("frame_end", PIX_W'(want.frame_end), PIX_W'(rsp_bus.frame_end));
         end
      end
   end

   // result side back-pressure, plus the long hold-off when a test asks for it
   always @(negedge clock) begin
      int roll;
      if (hold_requests != hold_taken) begin
         hold_taken = hold_requests;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_calm > 0) begin
         rsp_calm--;
         rsp_bus.ready <= 1'b1;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 70) begin
            rsp_bus.ready <= 1'b1;
         end else if (roll < 92) begin
            rsp_bus.ready <= 1'b0;
            rsp_stall = $urandom_range(0, 2);
         end else if (roll < 97) begin
            rsp_bus.ready <= 1'b0;
            rsp_stall = $urandom_range(9, 39);
         end else begin
            rsp_bus.ready <= 1'b1;
            rsp_calm = $urandom_range(50, 200);
         end
      end
   end

   function automatic pix_vec_type random_pixel();
      pix_vec_type pix;
      int          ch;
      for (ch = 0; ch < NUM_CH; ch++) begin
         case ($urandom_range(0, 9))
            0: pix[ch] = '0;
            1: pix[ch] = '1;
            default: pix[ch] = PIX_W'($urandom);
         endcase
      end
      return pix;
   endfunction

   task automatic send_pixel(input pix_vec_type pix, input logic fs);
      int gap;
      int roll;
      gap = 0;
      if (req_calm > 0) begin
         req_calm--;
      end else if (!no_req_gaps) begin
         roll = $urandom_range(0, 99);
         if (roll < 65)
            gap = 0;
         else if (roll < 90)
            gap = $urandom_range(1, 3);
         else if (roll < 96)
            gap = $urandom_range(8, 30);
         else
            req_calm = $urandom_range(30, 120);
      end
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.blue_in     <= pix[0];
      req_bus.green_in    <= pix[1];
      req_bus.red_in      <= pix[2];
      req_bus.frame_start <= fs;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      accumulate_pixel(pix, fs);
      pixels_sent++;
   endtask

   // marks the first pixel and every mark_every-th after it, with the odd stray mark if asked
   task automatic send_frames(input int total, input int mark_every, input bit stray_marks);
      int   i;
      logic fs;
      for (i = 0; i < total; i++) begin
         fs = (i % mark_every == 0) || (stray_marks && $urandom_range(0, 149) == 0);
         send_pixel(random_pixel(), fs);
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_averages.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_SOURCE_WIDTH:  set_src_w = data;
         CSR_SOURCE_HEIGHT: set_src_h = data;
         CSR_OUTPUT_WIDTH:  set_out_w = data[OW_CFG_W-1:0];
         CSR_OUTPUT_HEIGHT: set_out_h = data;
         default: ;
      endcase
   endtask

   task automatic apply_setup(input logic [CSR_DATA_W-1:0] sw, input logic [CSR_DATA_W-1:0] sh,
                              input logic [CSR_DATA_W-1:0] ow, input logic [CSR_DATA_W-1:0] oh);
      wait_idle();
      write_csr(CSR_SOURCE_WIDTH, sw);
      write_csr(CSR_SOURCE_HEIGHT, sh);
      write_csr(CSR_OUTPUT_WIDTH, ow);
      write_csr(CSR_OUTPUT_HEIGHT, oh);
      settings_applied++;
   endtask

   // start of a 1080p line under the register defaults, then a narrow source
   // with the remaining registers still at their defaults
   task automatic test_reset_config();
      send_frames(60, 60, 1'b0);
      wait_idle();
      write_csr(CSR_SOURCE_WIDTH, 13'd6);
      send_frames(36, 36, 1'b0);
   endtask

   task automatic test_extremes();
      int i;
      apply_setup(13'd3, 13'd3, 13'd1, 13'd1);
      for (i = 0; i < 9; i++)
         send_pixel('1, i == 0);
      // no mark: the frame wraps after its third line
      for (i = 0; i < 9; i++)
         send_pixel('0, 1'b0);
      // a block cut short by a new frame mark
      for (i = 0; i < 4; i++)
         send_pixel(random_pixel(), i == 0);
      for (i = 0; i < 9; i++)
         send_pixel((i % 2) ? {8'h55, 8'hAA, 8'h0F} : {8'hAA, 8'h55, 8'hF0}, i == 0);
   endtask

   task automatic test_zero_output();
      apply_setup(13'd3, 13'd3, 13'd0, 13'd1);
      send_frames(9, 9, 1'b0);
      apply_setup(13'd3, 13'd3, 13'd1, 13'd0);
      send_frames(9, 9, 1'b0);
      // zero source sizes read as one pixel per frame
      apply_setup(13'd0, 13'd0, 13'd1, 13'd1);
      send_frames(9, 9, 1'b0);
   endtask

   task automatic test_partial_blocks();
      apply_setup(13'd8, 13'd7, 13'd3, 13'd3);
      send_frames(2 * 56, 56, 1'b0);
   endtask

   // widths above the supported range saturate
   task automatic test_widest_line();
      apply_setup(13'd6, 13'd6, 13'h7FF, 13'd2);
      send_frames(36, 36, 1'b0);
      apply_setup(13'h1FFF, 13'd3, 13'd1, 13'd1);
      send_frames(12, 12, 1'b0);
   endtask

   // heights above the supported range saturate
   task automatic test_tallest_frame();
      apply_setup(13'd3, 13'h1FFF, 13'd1, 13'h1FFF);
      send_frames(45, 45, 1'b0);
   endtask

   task automatic test_input_stall();
      apply_setup(13'd6, 13'd12, 13'd2, 13'd4);
      no_req_gaps = 1'b1;
      hold_requests++;
      send_frames(2 * 72, 72, 1'b0);
      no_req_gaps = 1'b0;
   endtask

   task automatic test_random_frames();
      int unsigned           used_start, due_start;
      int                    frames, frame_len, n, mark_every;
      logic [CSR_DATA_W-1:0] sw, sh, ow, oh;
      used_start = pixels_used;
      due_start  = results_due;
      while (pixels_used - used_start < 150 || results_due - due_start < 15) begin
         case ($urandom_range(0, 9))
            0: sw = CSR_DATA_W'($urandom);
            1: sw = CSR_DATA_W'($urandom_range(0, 60));
            default: sw = CSR_DATA_W'($urandom_range(1, 24));
         endcase
         case ($urandom_range(0, 9))
            0: sh = CSR_DATA_W'($urandom);
            1: sh = CSR_DATA_W'($urandom_range(0, 30));
            default: sh = CSR_DATA_W'($urandom_range(1, 12));
         endcase
         case ($urandom_range(0, 9))
            0, 1: ow = CSR_DATA_W'($urandom);
            2, 3: ow = CSR_DATA_W'(effective_dim(sw) / FACTOR);
            default: ow = CSR_DATA_W'($urandom_range(0, 8));
         endcase
         case ($urandom_range(0, 9))
            0: oh = CSR_DATA_W'($urandom);
            1, 2: oh = CSR_DATA_W'(effective_dim(sh) / FACTOR);
            default: oh = CSR_DATA_W'($urandom_range(0, 5));
         endcase
         apply_setup(sw, sh, ow, oh);

         frame_len = effective_dim(sw) * effective_dim(sh);
         frames    = $urandom_range(1, 3);
         n         = frames * frame_len;
         if (n > 100)
            n = 100;
         else if ($urandom_range(0, 7) == 0)
            n = $urandom_range(1, n);
         // either every frame marked, or the first and the rest by wrap, plus any stray marks
         mark_every = $urandom_range(0, 1) ? frame_len : n;
         send_frames(n, mark_every, 1'b1);
      end
   endtask

   initial begin
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_index           = CSR_SOURCE_WIDTH;
      csr_wr_data         = '0;
      req_bus.valid       = 1'b0;
      req_bus.blue_in     = '0;
      req_bus.green_in    = '0;
      req_bus.red_in      = '0;
      req_bus.frame_start = 1'b0;
      rsp_bus.ready       = 1'b0;
      set_src_w           = SRC_W_RST;
      set_src_h           = SRC_H_RST;
      set_out_w           = OUT_W_RST;
      set_out_h           = OUT_H_RST;
      restart_frame();

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_config();
      test_extremes();
      test_zero_output();
      test_partial_blocks();
      test_input_stall();
      test_random_frames();
      test_widest_line();
      test_tallest_frame();
      wait_idle();

      $display("sent %0d source pixels, %0d of them inside averaged blocks; %0d averages checked",
               pixels_sent, pixels_used, results_seen);
      $display("covered reset defaults and %0d register settings, zero and saturated sizes",
               settings_applied);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
